>>> hdl/assert_macros.svh
// Assertion macros shared by the date adder RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

>>> hdl/gdad_pkg.sv
// Package with types, constants and calendar functions of the date adder.
package gdad_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned ADD_W   = 12;
   localparam int unsigned ACC_W   = 13;   // day plus offset, up to 4126
   localparam int unsigned QUO_W   = 8;    // year / 100 for years below 16384
   localparam int unsigned REM_W   = 7;    // year % 100

   localparam logic [YEAR_W-1:0]  MAX_YEAR        = YEAR_W'(9999);
   localparam logic [ADD_W-1:0]   MAX_OFFSET_DAYS = ADD_W'(4095);
   localparam logic [MONTH_W-1:0] LAST_MONTH      = MONTH_W'(12);
   localparam logic [MONTH_W-1:0] FIRST_MONTH     = MONTH_W'(1);
   localparam logic [DAY_W-1:0]   LAST_DAY        = DAY_W'(31);

   // floor(y / 100) = (y * 5243) >> 19, exact for every 14-bit year
   localparam logic [12:0] RECIP_100 = 13'd5243;
   localparam int unsigned RECIP_SHIFT = 19;
   localparam logic [REM_W-1:0] CENTURY_LAST = REM_W'(99);

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_INVALID  = 2'd1,
      ST_OVERFLOW = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_QUOT,
      S_CHECK,
      S_ROLL,
      S_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic quot;
      logic check;
      logic step;
   } cmd_type;

   typedef struct packed {
      logic invalid;
      logic more;
      logic ovf;
   } stat_type;

   // Leap year from the low year bits, the year modulo 100 and the century modulo 4.
   function automatic logic is_leap(input logic [1:0] y_low, input logic [REM_W-1:0] r100,
                                    input logic [1:0] q_low);
      is_leap = (y_low == 2'd0) && ((r100 != '0) || (q_low == 2'd0));
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                  input logic leap);
      case (m) inside
         4'd4, 4'd6, 4'd9, 4'd11: month_len = DAY_W'(30);
         4'd2:                    month_len = leap ? DAY_W'(29) : DAY_W'(28);
         default:                 month_len = DAY_W'(31);
      endcase
   endfunction

endpackage

>>> hdl/gdad_ctrl.sv
// Sequencer of the date adder: load, century split, check, monthly rollover.
module gdad_ctrl import gdad_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  stat_type stat,
   output cmd_type  cmd,
   output logic     busy,
   output logic     done
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      done     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = S_QUOT;
            end
         end
         S_QUOT: begin
            cmd.quot = 1'b1;
            state_in = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = stat.invalid ? S_DONE : S_ROLL;
         end
         S_ROLL: begin
            cmd.step = 1'b1;
            if (!stat.more || stat.ovf) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            done     = 1'b1;
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

>>> hdl/gdad_dpath.sv
// Datapath of the date adder: date registers, leap tracking and rollover step.
module gdad_dpath import gdad_pkg::*; (
   input  logic                clock,
   input  cmd_type             cmd,
   input  logic [DAY_W-1:0]    in_day,
   input  logic [MONTH_W-1:0]  in_month,
   input  logic [YEAR_W-1:0]   in_year,
   input  logic [ADD_W-1:0]    add_days,
   output stat_type            stat,
   output logic [DAY_W-1:0]    out_day,
   output logic [MONTH_W-1:0]  out_month,
   output logic [YEAR_W-1:0]   out_year,
   output status_type          out_status
);

   logic [ACC_W-1:0]   d_ff;
   logic [MONTH_W-1:0] m_ff;
   logic [YEAR_W-1:0]  y_ff;
   logic [ADD_W-1:0]   add_ff;
   logic [QUO_W-1:0]   q_ff;
   logic [REM_W-1:0]   r100_ff;
   logic [1:0]         q4_ff;
   status_type         st_ff;

   logic [YEAR_W+12:0] prod;
   logic [YEAR_W-1:0]  cent;
   logic [REM_W-1:0]   r100_chk;
   logic [DAY_W-1:0]   len_chk, len_run;
   logic               wrap;
   logic [ADD_W-1:0]   add_sat;

   assign add_sat  = (add_days > MAX_OFFSET_DAYS) ? MAX_OFFSET_DAYS : add_days;
   assign prod     = y_ff * RECIP_100;
   assign cent     = q_ff * YEAR_W'(100);
   assign r100_chk = REM_W'(y_ff - cent);
   assign len_chk  = month_len(m_ff, is_leap(y_ff[1:0], r100_chk, q_ff[1:0]));
   assign len_run  = month_len(m_ff, is_leap(y_ff[1:0], r100_ff, q4_ff));
   assign wrap     = (m_ff >= LAST_MONTH);

   always_comb begin
      stat.invalid = (d_ff == '0) || (m_ff == '0) || (m_ff > LAST_MONTH) ||
                     (y_ff == '0) || (y_ff > MAX_YEAR) ||
                     (d_ff > ACC_W'(len_chk));
      stat.more    = (d_ff > ACC_W'(len_run));
      stat.ovf     = stat.more && wrap && (y_ff >= MAX_YEAR);
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         d_ff   <= ACC_W'(in_day);
         m_ff   <= in_month;
         y_ff   <= in_year;
         add_ff <= add_sat;
      end
      if (cmd.quot) begin
         q_ff <= QUO_W'(prod >> RECIP_SHIFT);
      end
      if (cmd.check) begin
         r100_ff <= r100_chk;
         q4_ff   <= q_ff[1:0];
         d_ff    <= d_ff + ACC_W'(add_ff);
         st_ff   <= stat.invalid ? ST_INVALID : ST_OK;
      end
      if (cmd.step && stat.more) begin
         if (stat.ovf) begin
            st_ff <= ST_OVERFLOW;
         end else begin
            d_ff <= d_ff - ACC_W'(len_run);
            if (wrap) begin
               m_ff <= FIRST_MONTH;
               y_ff <= y_ff + YEAR_W'(1);
               if (r100_ff == CENTURY_LAST) begin
                  r100_ff <= '0;
                  q4_ff   <= q4_ff + 2'd1;
               end else begin
                  r100_ff <= r100_ff + REM_W'(1);
               end
            end else begin
               m_ff <= m_ff + MONTH_W'(1);
            end
         end
      end
   end

   always_comb begin
      out_status = st_ff;
      case (st_ff)
         ST_OK: begin
            out_day   = d_ff[DAY_W-1:0];
            out_month = m_ff;
            out_year  = y_ff;
         end
         ST_OVERFLOW: begin
            out_day   = LAST_DAY;
            out_month = LAST_MONTH;
            out_year  = MAX_YEAR;
         end
         default: begin
            out_day   = '0;
            out_month = '0;
            out_year  = '0;
         end
      endcase
   end

endmodule

>>> hdl/gregorian_date_add_days.sv
// Top level of the Gregorian date adder: sequencer plus datapath.
//
//   Channel   Handshake             Payload
//   request   start / busy          req_in_day, req_in_month, req_in_year, req_add_days
//   response  rsp_strobe (1 cycle)  rsp_out_day, rsp_out_month, rsp_out_year, rsp_status
//
// A request is taken when start is high and busy is low. Each request passes
// through set-up (capture, century split of the year, validity check), then
// one rollover step per month rolled over plus one in which the date is found
// settled, then the done state with the result on the ports. An invalid date
// goes straight from the validity check to the done state.
// Reset is synchronous and returns the sequencer to idle; the receiver cannot
// stall, so rsp_strobe lasts one cycle.
`include "assert_macros.svh"

module gregorian_date_add_days import gdad_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [DAY_W-1:0]   req_in_day,
   input  logic [MONTH_W-1:0] req_in_month,
   input  logic [YEAR_W-1:0]  req_in_year,
   input  logic [ADD_W-1:0]   req_add_days,
   output logic               rsp_strobe,
   output logic [DAY_W-1:0]   rsp_out_day,
   output logic [MONTH_W-1:0] rsp_out_month,
   output logic [YEAR_W-1:0]  rsp_out_year,
   output logic [1:0]         rsp_status
);

   cmd_type    cmd;
   stat_type   stat;
   status_type status;
   logic       ok_date_shape;
   logic       zero_date;

   // The sequencer steps the datapath through one request at a time.
   gdad_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .cmd   (cmd),
      .busy  (busy),
      .done  (rsp_strobe)
   );

   // The datapath holds the date and keeps the leap-year terms up to date
   // as the year advances, so no division is needed inside the loop.
   gdad_dpath u_dpath (
      .clock      (clock),
      .cmd        (cmd),
      .in_day     (req_in_day),
      .in_month   (req_in_month),
      .in_year    (req_in_year),
      .add_days   (req_add_days),
      .stat       (stat),
      .out_day    (rsp_out_day),
      .out_month  (rsp_out_month),
      .out_year   (rsp_out_year),
      .out_status (status)
   );

   assign rsp_status = status;

   // Shapes of the result date that the checks below expect.
   assign ok_date_shape = (rsp_out_month >= FIRST_MONTH) && (rsp_out_month <= LAST_MONTH) &&
                          (rsp_out_day != '0);
   assign zero_date     = (rsp_out_day == '0) && (rsp_out_month == '0) && (rsp_out_year == '0);

   // An accepted request always keeps the block busy in the next cycle.
   `ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // A result is a single-cycle strobe.
   `ASSERT_NEXT(a_strobe_single, clock, reset, rsp_strobe, !rsp_strobe)
   // A good result carries a plausible date.
   `ASSERT_SAME(a_ok_date, clock, reset, rsp_strobe && (rsp_status == ST_OK), ok_date_shape)
   // An invalid request returns an all-zero date.
   `ASSERT_SAME(a_invalid_zero, clock, reset, rsp_strobe && (rsp_status == ST_INVALID), zero_date)

endmodule

>>> tb/tb.sv
// Self-checking testbench for the Gregorian date adder, with directed and random requests.
module tb import gdad_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // The limit below covers both the rollover loop of a request and the
   // longest sender gap.
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   // Cycles allowed after the last result before the verdict is given.
   localparam int unsigned DRAIN_CYCLES   = 160;
   localparam int unsigned REPORT_LIMIT   = 10;
   localparam int unsigned RANDOM_PER_PHASE = 520;

   // One predicted result of the date adder.
   typedef struct packed {
      logic [DAY_W-1:0]   day;
      logic [MONTH_W-1:0] month;
      logic [YEAR_W-1:0]  year;
      status_type         status;
   } date_result_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [DAY_W-1:0]   req_in_day;
   logic [MONTH_W-1:0] req_in_month;
   logic [YEAR_W-1:0]  req_in_year;
   logic [ADD_W-1:0]   req_add_days;
   logic               rsp_strobe;
   logic [DAY_W-1:0]   rsp_out_day;
   logic [MONTH_W-1:0] rsp_out_month;
   logic [YEAR_W-1:0]  rsp_out_year;
   logic [1:0]         rsp_status;

   // Results predicted for accepted requests, oldest first.
   date_result_type expected_dates[$];

   int unsigned fail_count;
   int unsigned requests_sent;
   int unsigned results_seen;
   int unsigned ok_seen;
   int unsigned invalid_seen;
   int unsigned overflow_seen;
   int unsigned idle_cycles;
   // Chance, in percent, that the sender leaves a gap before a request.
   int unsigned sender_idle_pct;

   gregorian_date_add_days dut (
      .clock         (clock),
      .reset         (reset),
      .start         (start),
      .busy          (busy),
      .req_in_day    (req_in_day),
      .req_in_month  (req_in_month),
      .req_in_year   (req_in_year),
      .req_add_days  (req_add_days),
      .rsp_strobe    (rsp_strobe),
      .rsp_out_day   (rsp_out_day),
      .rsp_out_month (rsp_out_month),
      .rsp_out_year  (rsp_out_year),
      .rsp_status    (rsp_status)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ------------------------------------------------------------------
   // Calendar predictor
   // ------------------------------------------------------------------

   // Gregorian rule: every fourth year, except centuries not divisible by 400.
   function automatic bit is_leap_year(input int unsigned yr);
      return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
   endfunction

   function automatic int unsigned days_in_month(input int unsigned mon, input int unsigned yr);
      case (mon)
         4, 6, 9, 11: return 30;
         2:           return is_leap_year(yr) ? 29 : 28;
         default:     return 31;
      endcase
   endfunction

   // Adds the offset to the start date, one month at a time, and gives the
   // date that results together with its status.
   function automatic date_result_type predict_date_sum(input int unsigned d,
                                                        input int unsigned m,
                                                        input int unsigned y,
                                                        input int unsigned a);
      date_result_type res;
      int unsigned     day;
      int unsigned     mon;
      int unsigned     yr;
      int unsigned     offset;
      day    = d;
      mon    = m;
      yr     = y;
      offset = a;
      if (day == 0 || mon == 0 || mon > int'(LAST_MONTH) || yr == 0 ||
          yr > int'(MAX_YEAR) || day > days_in_month(mon, yr)) begin
         res.day    = '0;
         res.month  = '0;
         res.year   = '0;
         res.status = ST_INVALID;
         return res;
      end
      if (offset > int'(MAX_OFFSET_DAYS))
         offset = int'(MAX_OFFSET_DAYS);
      day = day + offset;
      // Each pass leaves the current month, using the leap status of its own year.
      while (day > days_in_month(mon, yr)) begin
         day = day - days_in_month(mon, yr);
         mon = mon + 1;
         if (mon > int'(LAST_MONTH)) begin
            mon = int'(FIRST_MONTH);
            yr  = yr + 1;
            if (yr > int'(MAX_YEAR)) begin
               res.day    = LAST_DAY;
               res.month  = LAST_MONTH;
               res.year   = MAX_YEAR;
               res.status = ST_OVERFLOW;
               return res;
            end
         end
      end
      res.day    = DAY_W'(day);
      res.month  = MONTH_W'(mon);
      res.year   = YEAR_W'(yr);
      res.status = ST_OK;
      return res;
   endfunction

   // ------------------------------------------------------------------
   // Checking
   // ------------------------------------------------------------------

   // At each rising edge a request is accepted when start is high and busy is
   // low; its prediction joins the queue. A strobed result is compared with
   // the oldest prediction, field by field.
   always @(posedge clock) begin
      date_result_type exp_res;
      if (!reset) begin
         if (start && !busy) begin
            expected_dates.push_back(predict_date_sum(req_in_day, req_in_month,
                                                      req_in_year, req_add_days));
            requests_sent++;
         end
         if (rsp_strobe) begin
            results_seen++;
            if (expected_dates.size() == 0) begin
               if (fail_count < REPORT_LIMIT)
                  $display("%0t: result with no request outstanding: %0d/%0d/%0d status %0d",
                           $realtime, rsp_out_day, rsp_out_month, rsp_out_year, rsp_status);
               fail_count++;
            end else begin
               exp_res = expected_dates.pop_front();
               case (exp_res.status)
                  ST_OK:       ok_seen++;
                  ST_INVALID:  invalid_seen++;
                  ST_OVERFLOW: overflow_seen++;
                  default:     ;
               endcase
               if (rsp_out_day !== exp_res.day || rsp_out_month !== exp_res.month ||
                   rsp_out_year !== exp_res.year || rsp_status !== exp_res.status) begin
                  if (fail_count < REPORT_LIMIT)
                     $display("%0t: expected %0d/%0d/%0d status %0d, got %0d/%0d/%0d status %0d",
                              $realtime, exp_res.day, exp_res.month, exp_res.year,
                              exp_res.status, rsp_out_day, rsp_out_month, rsp_out_year,
                              rsp_status);
                  fail_count++;
               end
            end
         end
      end
   end

   // Watchdog: counts cycles in which neither a request nor a result moves.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog expired after %0d quiet cycles, %0d results outstanding",
                  idle_cycles, expected_dates.size());
         $display("[gregorian_date_add_days] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------

   // Drives one request at a falling edge, after a random gap when the phase
   // asks for one, and holds it until a rising edge accepts it. Start is left
   // high afterwards; the block is busy by then, so nothing is taken twice.
   task automatic send_request(input int unsigned d, input int unsigned m,
                               input int unsigned y, input int unsigned a);
      int unsigned gap;
      gap = 0;
      if ($urandom_range(0, 99) < sender_idle_pct)
         gap = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 4) : $urandom_range(5, 150);
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_in_day   = DAY_W'(d);
      req_in_month = MONTH_W'(m);
      req_in_year  = YEAR_W'(y);
      req_add_days = ADD_W'(a);
      start        = 1'b1;
      do @(posedge clock); while (busy);
   endtask

   // Lowers start and waits until every predicted result has arrived, then
   // a little longer so that a stray result would still be caught.
   task automatic drain_results();
      @(negedge clock);
      start = 1'b0;
      while (expected_dates.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Each field outside the valid range, and day past the end of the month.
   task automatic test_invalid_dates();
      sender_idle_pct = 0;
      send_request(0, 1, 2000, 5);          // day of zero
      send_request(1, 0, 2000, 5);          // month of zero
      send_request(1, 13, 2000, 5);         // first month past December
      send_request(31, 15, 16383, 4095);    // every field at its widest
      send_request(1, 1, 0, 5);             // year of zero
      send_request(1, 1, 10000, 5);         // year just past the maximum
      send_request(31, 4, 2021, 0);         // thirty-first of a thirty-day month
      send_request(29, 2, 1900, 0);         // leap day in a plain century year
      send_request(30, 2, 2000, 0);         // past the leap day of a leap year
      drain_results();
   endtask

   // The smallest and largest dates and offsets, rollover across months and
   // years, and the leap rule in its three forms.
   task automatic test_calendar_edges();
      sender_idle_pct = 0;
      send_request(1, 1, 1, 0);             // earliest date, no offset
      send_request(31, 12, 9999, 0);        // latest date, no offset
      send_request(31, 1, 2023, 1);         // end of month to the next month
      send_request(31, 12, 2023, 1);        // end of year to the next year
      send_request(28, 2, 2000, 1);         // leap day of a 400-year century
      send_request(28, 2, 1900, 1);         // no leap day in a plain century
      send_request(28, 2, 2024, 1);         // ordinary leap year
      send_request(29, 2, 2400, 365);       // from a leap day, a year on
      send_request(1, 1, 2000, 4095);       // largest offset
      send_request(1, 1, 1, 4095);          // largest offset from the first year
      drain_results();
   endtask

   // Carry past the last year saturates to the last representable date.
   task automatic test_year_overflow();
      sender_idle_pct = 0;
      send_request(31, 12, 9999, 1);        // one day past the end
      send_request(1, 1, 9990, 4095);       // large offset near the end
      send_request(1, 12, 9999, 30);        // last day of the range exactly
      send_request(2, 12, 9999, 30);        // one day further
      drain_results();
   endtask

   function automatic int unsigned pick_year();
      case ($urandom_range(0, 4))
         0:       return $urandom_range(1, int'(MAX_YEAR));
         1:       return $urandom_range(int'(MAX_YEAR) - 14, int'(MAX_YEAR));
         2:       return $urandom_range(1, 99) * 100 + $urandom_range(0, 2) - 1;
         3:       return $urandom_range(8192, int'(MAX_YEAR));
         default: return $urandom_range(1, 50);
      endcase
   endfunction

   function automatic int unsigned pick_offset();
      case ($urandom_range(0, 4))
         0:       return $urandom_range(0, 4095);
         1:       return $urandom_range(0, 62);
         2:       return $urandom_range(4000, 4095);
         default: return $urandom_range(0, 400);
      endcase
   endfunction

   // Mostly valid start dates with random offsets; about one request in
   // seven carries raw field values so that invalid dates keep turning up.
   task automatic test_random_dates(input int unsigned idle_pct, input int unsigned count);
      int unsigned m;
      int unsigned y;
      sender_idle_pct = idle_pct;
      repeat (count) begin
         if ($urandom_range(0, 6) == 0) begin
            send_request($urandom_range(0, 31), $urandom_range(0, 15),
                         $urandom_range(0, 16383), $urandom_range(0, 4095));
         end else begin
            m = $urandom_range(1, 12);
            y = pick_year();
            if (y == 0 || y > int'(MAX_YEAR))
               y = int'(MAX_YEAR);
            // The last day of a month is favoured, as that is where rollover bites.
            send_request(($urandom_range(0, 3) == 0) ? days_in_month(m, y)
                                                     : $urandom_range(1, days_in_month(m, y)),
                         m, y, pick_offset());
         end
      end
      drain_results();
   endtask

   // ------------------------------------------------------------------
   // Sequence of the run
   // ------------------------------------------------------------------

   initial begin
      reset         = 1'b1;
      start         = 1'b0;
      req_in_day    = '0;
      req_in_month  = '0;
      req_in_year   = '0;
      req_add_days  = '0;
      fail_count    = 0;
      requests_sent = 0;
      results_seen  = 0;
      ok_seen       = 0;
      invalid_seen  = 0;
      overflow_seen = 0;
      idle_cycles   = 0;
      sender_idle_pct = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_invalid_dates();
      test_calendar_edges();
      test_year_overflow();
      // The receiver cannot hold results off, so only the sender idles:
      // back to back, then often, then now and then.
      test_random_dates(0, RANDOM_PER_PHASE);
      test_random_dates(48, RANDOM_PER_PHASE);
      test_random_dates(22, RANDOM_PER_PHASE);

      $display("Covered %0d requests, %0d results: %0d ok, %0d invalid, %0d overflow.",
               requests_sent, results_seen, ok_seen, invalid_seen, overflow_seen);
      $display("Sender gaps of none, 48 and 22 percent; %0d failures found.", fail_count);
      if (fail_count == 0 && expected_dates.size() == 0) begin
         $display("[gregorian_date_add_days] OK");
      end else begin
         $display("[gregorian_date_add_days] ERROR");
      end
      $finish;
   end

endmodule

>>> sim.f
+incdir+hdl
hdl/gdad_pkg.sv
hdl/gdad_ctrl.sv
hdl/gdad_dpath.sv
hdl/gregorian_date_add_days.sv
tb/tb.sv
